// File: rtl/assert_macros.svh
// Assertion macros used by the checker file apdt_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock with an active-low reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/apdt_pkg.sv
`default_nettype none
package apdt_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam logic [7:0] LIFETIME_RESET = 8'd10;
    localparam int COORD_W = 24;
    localparam int RADIUS_W = 23;
    localparam int COUNT_W = 7;
    localparam int LIFE_W = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0]
    {
        REQ_ADD   = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed
    {
        req_t                         op;
        logic signed [COORD_W-1:0]    x;
        logic signed [COORD_W-1:0]    y;
        logic signed [COORD_W-1:0]    z;
        logic        [RADIUS_W-1:0]   radius;
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_MIN,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// File: rtl/apdt_front.sv
`default_nettype none
module apdt_front
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 valid,
    output logic                                      stall,
    input  wire logic [1:0]                           req_type,
    input  wire logic signed [apdt_pkg::COORD_W-1:0]  coord_x,
    input  wire logic signed [apdt_pkg::COORD_W-1:0]  coord_y,
    input  wire logic signed [apdt_pkg::COORD_W-1:0]  coord_z,
    input  wire logic [apdt_pkg::RADIUS_W-1:0]        radius,
    output logic                                      q_valid,
    output apdt_pkg::cmd_t                            q_cmd,
    input  wire logic                                 q_pop
);
    import apdt_pkg::*;

    cmd_t q_reg [QUEUE_DEPTH];
    cmd_t cmd_in;
    logic rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    always_comb
    begin
        cmd_in.op = req_t'(req_type);
        cmd_in.x = coord_x;
        cmd_in.y = coord_y;
        cmd_in.z = coord_z;
        cmd_in.radius = radius;
    end

    assign stall = (cnt_reg == 2'(QUEUE_DEPTH));
    assign push = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end
endmodule
`default_nettype wire

// File: rtl/apdt_back.sv
`default_nettype none
module apdt_back
#(
    parameter int TABLE_DEPTH = apdt_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [apdt_pkg::LIFE_W-1:0]      cfg_wdata,
    input  wire logic                             q_valid,
    input  wire apdt_pkg::cmd_t                   q_cmd,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [apdt_pkg::COUNT_W-1:0]          near_count,
    output logic                                  add_dropped
);
    import apdt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = COORD_W + 2;

    state_t state_reg, state_next;
    logic [LIFE_W-1:0] lifetime_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [LIFE_W-1:0] life_reg [TABLE_DEPTH];
    logic signed [COORD_W-1:0] ex_reg [TABLE_DEPTH];
    logic signed [COORD_W-1:0] ey_reg [TABLE_DEPTH];
    logic signed [COORD_W-1:0] ez_reg [TABLE_DEPTH];
    cmd_t cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] nx_reg, ny_reg, nz_reg;
    logic [COUNT_W-1:0] count_reg;
    logic drop_reg;
    logic acc_reg;
    logic rd_v_reg;
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic last;
    logic hx, hy, hz;
    logic [IDX_W-1:0] free_idx;
    logic free_any;
    logic [CNT_W-1:0] m1, m2;

    function automatic logic near_f(input logic signed [COORD_W-1:0] e,
                                    input logic signed [COORD_W-1:0] c,
                                    input logic [RADIUS_W-1:0] r);
        logic signed [EXT_W-1:0] d;
        begin
            d = EXT_W'(e) - EXT_W'(c);
            if (d < 0)
            begin
                d = -d;
            end
            return d <= $signed({3'b000, r});
        end
    endfunction

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // scan reads are registered; counts accumulate in the cycle after the read
    assign last = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
    assign hx = rd_v_reg && near_f(rd_x_reg, cmd_reg.x, cmd_reg.radius);
    assign hy = rd_v_reg && near_f(rd_y_reg, cmd_reg.y, cmd_reg.radius);
    assign hz = rd_v_reg && near_f(rd_z_reg, cmd_reg.z, cmd_reg.radius);
    assign m1 = (ny_reg < nx_reg) ? ny_reg : nx_reg;
    assign m2 = (nz_reg < m1) ? nz_reg : m1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_cmd.op == REQ_QUERY) ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: if (last) state_next = ST_MIN;
            ST_MIN:
            begin
                if (!acc_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:  if (!out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == ST_IDLE) && q_valid;
        out_valid = (state_reg == ST_OUT);
        near_count = count_reg;
        add_dropped = drop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lifetime_reg <= LIFETIME_RESET;
            valid_reg <= '0;
            acc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= (state_reg == ST_SCAN);
            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end
            if (q_pop && q_cmd.op == REQ_ADD && free_any)
            begin
                valid_reg[free_idx] <= 1'b1;
            end
            if (q_pop && q_cmd.op == REQ_TICK)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (life_reg[i] <= LIFE_W'(1))
                    begin
                        valid_reg[i] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            idx_reg <= '0;
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
            count_reg <= '0;
            drop_reg <= (q_cmd.op == REQ_ADD) && !free_any;
            if (q_cmd.op == REQ_ADD && free_any)
            begin
                ex_reg[free_idx] <= q_cmd.x;
                ey_reg[free_idx] <= q_cmd.y;
                ez_reg[free_idx] <= q_cmd.z;
                life_reg[free_idx] <= lifetime_reg;
            end
            if (q_cmd.op == REQ_TICK)
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (valid_reg[i] && life_reg[i] > LIFE_W'(1))
                    begin
                        life_reg[i] <= life_reg[i] - LIFE_W'(1);
                    end
                end
            end
        end
        if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            rd_v_reg <= valid_reg[idx_reg];
            rd_x_reg <= ex_reg[idx_reg];
            rd_y_reg <= ey_reg[idx_reg];
            rd_z_reg <= ez_reg[idx_reg];
        end
        if (acc_reg)
        begin
            nx_reg <= nx_reg + CNT_W'(hx);
            ny_reg <= ny_reg + CNT_W'(hy);
            nz_reg <= nz_reg + CNT_W'(hz);
        end
        if (state_reg == ST_MIN && !acc_reg)
        begin
            if (32'(m2) > 32'd127)
            begin
                count_reg <= '1;
            end
            else
            begin
                count_reg <= COUNT_W'(m2);
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/aging_point_density_table.sv
// Aging point density table.
// Input channel: in_valid/in_stall with req_type, coord_x/y/z, radius.
// Output channel: out_valid/out_stall with near_count and add_dropped,
// one transfer per accepted request, in order.
// Configuration: cfg_we/cfg_wdata writes entry_lifetime (reset 10).
// A two-entry queue sits between the input stage and the execution unit.
// An add or tick passes from the queue straight to the result; a query
// first scans the table, one entry per cycle, then takes the minimum.
// The execution unit takes a new request only once the last result has
// been taken, so the scan sets the pace for queries.
// Reset empties the table and the queue; no clearing pass is needed.
// While out_stall is high the result holds and the execution unit waits;
// the queue keeps taking input until it is full, then in_stall rises.
`default_nettype none
module aging_point_density_table
#(
    parameter int TABLE_DEPTH = apdt_pkg::TABLE_DEPTH_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [apdt_pkg::LIFE_W-1:0]          cfg_wdata,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           req_type,
    input  wire logic signed [apdt_pkg::COORD_W-1:0]  coord_x,
    input  wire logic signed [apdt_pkg::COORD_W-1:0]  coord_y,
    input  wire logic signed [apdt_pkg::COORD_W-1:0]  coord_z,
    input  wire logic [apdt_pkg::RADIUS_W-1:0]        radius,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [apdt_pkg::COUNT_W-1:0]              near_count,
    output logic                                      add_dropped
);
    import apdt_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    apdt_front u_front
    (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .req_type(req_type), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .radius(radius),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    apdt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .near_count(near_count), .add_dropped(add_dropped)
    );
endmodule
`default_nettype wire

// File: rtl/apdt_checker.sv
`default_nettype none
`include "assert_macros.svh"
module apdt_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [6:0] near_count,
    input wire logic       add_dropped
);
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
    `CHK_NEXT(a_cnt_stable, clk, rst_n, out_valid && out_stall, $stable(near_count), "count moved")
    `CHK_ALWAYS(a_excl, clk, rst_n, !(out_valid && add_dropped && near_count != 7'd0), "drop and count")
endmodule

bind aging_point_density_table apdt_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .near_count(near_count), .add_dropped(add_dropped)
);
`default_nettype wire

// File: test/testbench.sv
`default_nettype none
module testbench;
    import apdt_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed
    {
        logic [COUNT_W-1:0] count;
        logic               dropped;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [LIFE_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic signed [COORD_W-1:0] coord_z = '0;
    logic [RADIUS_W-1:0] radius = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [COUNT_W-1:0] near_count;
    logic add_dropped;

    aging_point_density_table i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .coord_z(coord_z),
        .radius(radius),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .near_count(near_count),
        .add_dropped(add_dropped)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // table copy used for prediction
    logic [LIFE_W-1:0] lifetime_set;
    logic tbl_valid [DEPTH];
    logic signed [COORD_W-1:0] tbl_x [DEPTH];
    logic signed [COORD_W-1:0] tbl_y [DEPTH];
    logic signed [COORD_W-1:0] tbl_z [DEPTH];
    logic [LIFE_W-1:0] tbl_life [DEPTH];

    cmd_t pending_cmds[$];
    answer_t expected_answers[$];
    int error_count = 0;
    int idle_cycles = 0;
    bit hold_request = 1'b0;
    bit hold_started = 1'b0;
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;

    function automatic bit near_axis(logic signed [COORD_W-1:0] p,
                                     logic signed [COORD_W-1:0] c,
                                     logic [RADIUS_W-1:0] r);
        longint d;
        d = longint'(p) - longint'(c);
        if (d < 0)
            d = -d;
        return d <= longint'({1'b0, r});
    endfunction

    task automatic queue_cmd(cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic apply_request(cmd_t c);
        answer_t a;
        int slot;
        int nx, ny, nz, m;
        a = '0;
        slot = -1;
        nx = 0; ny = 0; nz = 0;
        case (c.op)
            REQ_ADD:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                if (slot < 0)
                    a.dropped = 1'b1;
                else
                begin
                    tbl_valid[slot] = 1'b1;
                    tbl_x[slot] = c.x;
                    tbl_y[slot] = c.y;
                    tbl_z[slot] = c.z;
                    tbl_life[slot] = lifetime_set;
                end
            end
            REQ_QUERY:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i])
                    begin
                        nx += near_axis(tbl_x[i], c.x, c.radius);
                        ny += near_axis(tbl_y[i], c.y, c.radius);
                        nz += near_axis(tbl_z[i], c.z, c.radius);
                    end
                m = nx;
                if (ny < m) m = ny;
                if (nz < m) m = nz;
                if (m > 127) m = 127;
                a.count = COUNT_W'(m);
            end
            REQ_TICK:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i])
                    begin
                        if (tbl_life[i] <= 1)
                        begin
                            tbl_life[i] = '0;
                            tbl_valid[i] = 1'b0;
                        end
                        else
                            tbl_life[i] = tbl_life[i] - 1'b1;
                    end
            end
            default: ;
        endcase
        expected_answers.insert(expected_answers.size(), a);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // driver
    int send_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_fire)
            begin
                // transfer still pending, hold the payload
            end
            else if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                in_valid <= 1'b1;
                req_type <= c.op;
                coord_x <= c.x;
                coord_y <= c.y;
                coord_z <= c.z;
                radius <= c.radius;
                apply_request(c);
                send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side: stall drawn per transfer, plus a long hold on request
    int recv_gap = 0;
    int hold_count = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && !hold_started)
            begin
                hold_started <= 1'b1;
                hold_count <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_count > 0)
            begin
                hold_count <= hold_count - 1;
                out_stall <= 1'b1;
            end
            else if (out_fire)
            begin
                recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
                out_stall <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            out_fire <= out_valid && !out_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected transfer", 1, 0);
                else
                begin
                    answer_t w;
                    w = expected_answers.pop_front();
                    if (near_count !== w.count)
                        report_mismatch("near_count", near_count, w.count);
                    if (add_dropped !== w.dropped)
                        report_mismatch("add_dropped", add_dropped, w.dropped);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] pick_coord(bit clustered);
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return clustered ? COORD_W'($signed($urandom_range(0, 2047)) - 1024)
                                      : COORD_W'($urandom);
        endcase
    endfunction

    function automatic cmd_t make_cmd(req_t op, bit clustered);
        cmd_t c;
        c.op = op;
        c.x = pick_coord(clustered);
        c.y = pick_coord(clustered);
        c.z = pick_coord(clustered);
        case ($urandom_range(0, 5))
            0: c.radius = '0;
            1: c.radius = '1;
            2: c.radius = RADIUS_W'($urandom);
            default: c.radius = RADIUS_W'($urandom_range(0, 1500));
        endcase
        return c;
    endfunction

    task automatic drain_and_write(logic [LIFE_W-1:0] value);
        while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        lifetime_set = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_cmd(make_cmd(REQ_ADD, 1'b1));
            else if (r < 75)
                queue_cmd(make_cmd(REQ_QUERY, 1'b1));
            else if (r < 95)
                queue_cmd(make_cmd(REQ_TICK, 1'b0));
            else
                queue_cmd(make_cmd(REQ_NONE, 1'b0));
        end
    endtask

    initial
    begin
        cmd_t c;
        lifetime_set = LIFETIME_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_x[i] = '0;
            tbl_y[i] = '0;
            tbl_z[i] = '0;
            tbl_life[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every request type, unknown request
        c = '0;
        c.op = REQ_QUERY;
        queue_cmd(c);
        c.op = REQ_ADD; c.x = 24'sh7FFFFF; c.y = 24'sh800000; c.z = '0;
        queue_cmd(c);
        c.x = 24'sh800000; c.y = 24'sh7FFFFF; c.z = '1;
        queue_cmd(c);
        c.op = REQ_QUERY; c.x = '0; c.y = '0; c.z = '0; c.radius = '1;
        queue_cmd(c);
        c.x = 24'sh7FFFFF; c.radius = '0;
        queue_cmd(c);
        c.op = REQ_NONE; c.x = '1; c.y = '1; c.z = '1; c.radius = '1;
        queue_cmd(c);
        c.op = REQ_TICK;
        queue_cmd(c);
        c.op = REQ_QUERY; c.x = 24'sh800000; c.y = 24'sh7FFFFF; c.z = '1;
        c.radius = RADIUS_W'(1);
        queue_cmd(c);

        // lifetime 0 and the full-table drop
        drain_and_write(8'd0);
        for (int n = 0; n < DEPTH + 3; n++)
            queue_cmd(make_cmd(REQ_ADD, 1'b1));
        c = make_cmd(REQ_QUERY, 1'b1);
        c.radius = '1;
        queue_cmd(c);
        c.op = REQ_TICK;
        queue_cmd(c);
        c.op = REQ_QUERY;
        queue_cmd(c);

        drain_and_write(8'd255);
        // long receiver hold while the sender keeps offering
        for (int n = 0; n < 30; n++)
            queue_cmd(make_cmd(REQ_ADD, 1'b1));
        hold_request = 1'b1;
        run_phase(400);

        drain_and_write(8'd1);
        run_phase(350);
        drain_and_write(8'd3);
        run_phase(350);
        drain_and_write(LIFE_W'($urandom_range(1, 254)));
        run_phase(350);
        drain_and_write(8'd40);
        run_phase(250);

        while (pending_cmds.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
